>>> rtl/c3s_pkg.sv
// Shared constants, types and term tables for the 3x3 Cramer solver.
// No dependencies; every rtl file imports this package.
package c3s_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned NUM_ELEM       = 9;
  localparam int unsigned NUM_RHS        = 3;
  localparam int unsigned NUM_TERMS      = 6;
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned OUT_FRAC       = 16;
  localparam int unsigned QUO_BITS       = OUT_W + 1;
  localparam int unsigned USER_W         = 2;
  localparam int unsigned USER_SING      = 0;
  localparam int unsigned USER_OVF       = 1;

  // Row-major element indexes of each determinant term, with the sign flip.
  localparam int unsigned TERM_IDX [NUM_TERMS][3] = '{
    '{0, 4, 8}, '{0, 5, 7}, '{1, 3, 8}, '{1, 5, 6}, '{2, 3, 7}, '{2, 4, 6}
  };
  localparam logic TERM_FLIP [NUM_TERMS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  typedef struct packed {
    logic singular;
    logic overflow;
  } c3s_flags_t;

endpackage

>>> rtl/c3s_det.sv
// Four-stage pipelined exact determinant of one 3x3 matrix.
// Depends on c3s_pkg for the term tables.
module c3s_det #(
  parameter int unsigned DW = c3s_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [c3s_pkg::NUM_ELEM-1:0][DW-1:0]   mat_i,
  output logic                                   valid_o,
  output logic signed [3*DW:0]                   det_o
);
  import c3s_pkg::*;

  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned TW   = 3 * DW;
  localparam int unsigned DETW = 3 * DW + 1;

  logic [DW-1:0]          mag [NUM_ELEM];
  logic                   neg [NUM_ELEM];
  logic [PW-1:0]          p1_d [NUM_TERMS];
  logic [PW-1:0]          p1_q [NUM_TERMS];
  logic [DW-1:0]          mk_d [NUM_TERMS];
  logic [DW-1:0]          mk_q [NUM_TERMS];
  logic                   sg1_d [NUM_TERMS];
  logic                   sg1_q [NUM_TERMS];
  logic [PW-1:0]          pl_q [NUM_TERMS];
  logic [PW-1:0]          ph_q [NUM_TERMS];
  logic                   sg2_q [NUM_TERMS];
  logic [TW-1:0]          tmag [NUM_TERMS];
  logic signed [DETW-1:0] term_d [NUM_TERMS];
  logic signed [DETW-1:0] term_q [NUM_TERMS];
  logic signed [DETW-1:0] det_d;
  logic signed [DETW-1:0] det_q;
  logic [3:0]             vld_q;

  always_comb begin
    for (int e = 0; e < NUM_ELEM; e++) begin
      neg[e] = mat_i[e][DW-1];
      mag[e] = neg[e] ? (DW'(0) - mat_i[e]) : mat_i[e];
    end
    for (int t = 0; t < NUM_TERMS; t++) begin
      p1_d[t]  = PW'(mag[TERM_IDX[t][0]]) * PW'(mag[TERM_IDX[t][1]]);
      mk_d[t]  = mag[TERM_IDX[t][2]];
      sg1_d[t] = neg[TERM_IDX[t][0]] ^ neg[TERM_IDX[t][1]] ^ neg[TERM_IDX[t][2]]
                 ^ TERM_FLIP[t];
    end
  end

  always_comb begin
    for (int t = 0; t < NUM_TERMS; t++) begin
      tmag[t]   = (TW'(ph_q[t]) << DW) + TW'(pl_q[t]);
      term_d[t] = sg2_q[t] ? -$signed({1'b0, tmag[t]}) : $signed({1'b0, tmag[t]});
    end
    det_d = ((term_q[0] + term_q[1]) + (term_q[2] + term_q[3]))
            + (term_q[4] + term_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
        p1_q[t]   <= p1_d[t];
        mk_q[t]   <= mk_d[t];
        sg1_q[t]  <= sg1_d[t];
        pl_q[t]   <= PW'(p1_q[t][DW-1:0]) * PW'(mk_q[t]);
        ph_q[t]   <= PW'(p1_q[t][PW-1:DW]) * PW'(mk_q[t]);
        sg2_q[t]  <= sg1_q[t];
        term_q[t] <= term_d[t];
      end
      det_q <= det_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign det_o   = det_q;

endmodule

>>> rtl/c3s_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding
// and Q16.16 saturation. Depends on c3s_pkg.
module c3s_div #(
  parameter int unsigned DW = c3s_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [3*DW:0]             num_i,
  input  logic signed [3*DW:0]             den_i,
  output logic                             valid_o,
  output logic signed [c3s_pkg::OUT_W-1:0] quo_o,
  output c3s_pkg::c3s_flags_t              flags_o
);
  import c3s_pkg::*;

  localparam int unsigned DETW  = 3 * DW + 1;
  localparam int unsigned MAGW  = 3 * DW;
  localparam int unsigned RW    = MAGW + 1;
  localparam int unsigned SH    = QUO_BITS - OUT_FRAC;
  localparam int unsigned NSTG  = QUO_BITS + 1;
  localparam int unsigned LIMW  = QUO_BITS + 1;

  logic [MAGW-1:0]     nmag_q;
  logic [MAGW-1:0]     dmag_q;
  logic                neg_q, sing_q, vld_a_q;

  logic [MAGW-1:0]     num_s [NSTG];
  logic [MAGW-1:0]     den_s [NSTG];
  logic [RW-1:0]       rem_s [NSTG];
  logic [QUO_BITS-1:0] q_s   [NSTG];
  logic                neg_s [NSTG];
  logic                big_s [NSTG];
  logic                sing_s[NSTG];
  logic                vld_s [NSTG];

  logic [MAGW-1:0]     rem0;
  logic [LIMW-1:0]     qr, limit, qsat;
  logic                rnd, ovf;
  logic [OUT_W-1:0]    u_d;
  logic [OUT_W-1:0]    u_q;
  c3s_flags_t          flags_d, flags_q;
  logic                vld_o_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_q <= num_i[DETW-1] ? MAGW'(-num_i) : MAGW'(num_i);
      dmag_q <= den_i[DETW-1] ? MAGW'(-den_i) : MAGW'(den_i);
      neg_q  <= num_i[DETW-1] ^ den_i[DETW-1];
      sing_q <= (den_i == '0);
    end
  end

  assign rem0 = nmag_q >> SH;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_s[0]  <= nmag_q;
      den_s[0]  <= dmag_q;
      rem_s[0]  <= RW'(rem0);
      q_s[0]    <= '0;
      neg_s[0]  <= neg_q;
      big_s[0]  <= (rem0 >= dmag_q);
      sing_s[0] <= sing_q;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    localparam int I = QUO_BITS - 1 - k;
    logic          nbit;
    logic [RW-1:0] r2;
    logic          ge;
    if (I >= OUT_FRAC) begin : g_bit
      assign nbit = num_s[k][I - OUT_FRAC];
    end else begin : g_zero
      assign nbit = 1'b0;
    end
    assign r2 = {rem_s[k][RW-2:0], nbit};
    assign ge = (r2 >= RW'(den_s[k]));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_s[k+1]  <= num_s[k];
        den_s[k+1]  <= den_s[k];
        rem_s[k+1]  <= ge ? (r2 - RW'(den_s[k])) : r2;
        q_s[k+1]    <= {q_s[k][QUO_BITS-2:0], ge};
        neg_s[k+1]  <= neg_s[k];
        big_s[k+1]  <= big_s[k];
        sing_s[k+1] <= sing_s[k];
      end
    end
  end

  always_comb begin
    rnd   = ({rem_s[NSTG-1][RW-2:0], 1'b0} >= RW'(den_s[NSTG-1]));
    qr    = LIMW'(q_s[NSTG-1]) + LIMW'(rnd);
    limit = neg_s[NSTG-1] ? (LIMW'(1) << (OUT_W - 1)) : ((LIMW'(1) << (OUT_W - 1)) - 1'b1);
    ovf   = big_s[NSTG-1] || (qr > limit);
    qsat  = ovf ? limit : qr;
    u_d   = neg_s[NSTG-1] ? (OUT_W'(0) - qsat[OUT_W-1:0]) : qsat[OUT_W-1:0];
    flags_d.singular = sing_s[NSTG-1];
    flags_d.overflow = ovf && !sing_s[NSTG-1];
    if (sing_s[NSTG-1]) begin
      u_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= u_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_o_q <= 1'b0;
      for (int s = 0; s < NSTG; s++) begin
        vld_s[s] <= 1'b0;
      end
    end else if (en_i) begin
      vld_a_q  <= valid_i;
      vld_s[0] <= vld_a_q;
      for (int s = 1; s < NSTG; s++) begin
        vld_s[s] <= vld_s[s-1];
      end
      vld_o_q <= vld_s[NSTG-1];
    end
  end

  assign valid_o = vld_o_q;
  assign quo_o   = $signed(u_q);
  assign flags_o = flags_q;

endmodule

>>> rtl/cramer_3x3_solver_top.sv
// The path from an accepted input beat to its output beat has 4 determinant stages,
// 2 setup stages, 33 divide stages and 1 output stage.
// Throughput: one system per cycle; the 33-stage bit-per-stage divider sets the depth.
// A stall on the output holds the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits asynchronously; data registers are not reset.
// Depends on c3s_pkg, c3s_det and c3s_div.
module cramer_3x3_solver_top #(
  parameter int unsigned DATA_WIDTH = c3s_pkg::DATA_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // a00 a01 a02 a10 a11 a12 a20 a21 a22 b0 b1 b2, zero padded to bytes
  input  logic [((12*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // u0 u1 u2
  output logic [3*c3s_pkg::OUT_W-1:0]               m_axis_tdata,
  // singular overflow
  output logic [c3s_pkg::USER_W-1:0]                m_axis_tuser
);
  import c3s_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned DETW = 3 * DW + 1;

  logic                          en;
  logic [NUM_ELEM-1:0][DW-1:0]   mat [4];
  logic signed [DETW-1:0]        det [4];
  logic                          det_vld;
  logic                          div_vld;
  logic signed [OUT_W-1:0]       quo [3];
  c3s_flags_t                    flg [3];

  assign en            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;

  for (genvar e = 0; e < NUM_ELEM; e++) begin : g_mat
    assign mat[0][e] = s_axis_tdata[e*DW +: DW];
    for (genvar c = 0; c < 3; c++) begin : g_col
      if ((e % 3) == c) begin : g_rhs
        assign mat[c+1][e] = s_axis_tdata[(NUM_ELEM + e/3)*DW +: DW];
      end else begin : g_keep
        assign mat[c+1][e] = s_axis_tdata[e*DW +: DW];
      end
    end
  end

  c3s_det #(.DW(DW)) u_det_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(s_axis_tvalid),
    .mat_i(mat[0]), .valid_o(det_vld), .det_o(det[0])
  );

  for (genvar c = 1; c < 4; c++) begin : g_det
    c3s_det #(.DW(DW)) u_det (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(s_axis_tvalid),
      .mat_i(mat[c]), .valid_o(), .det_o(det[c])
    );
  end

  c3s_div #(.DW(DW)) u_div0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(det_vld),
    .num_i(det[1]), .den_i(det[0]), .valid_o(div_vld), .quo_o(quo[0]), .flags_o(flg[0])
  );

  for (genvar c = 1; c < 3; c++) begin : g_div
    c3s_div #(.DW(DW)) u_div (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(det_vld),
      .num_i(det[c+1]), .den_i(det[0]), .valid_o(), .quo_o(quo[c]), .flags_o(flg[c])
    );
  end

  assign m_axis_tvalid = div_vld;
  assign m_axis_tdata  = {quo[2], quo[1], quo[0]};
  assign m_axis_tuser[USER_SING] = flg[0].singular;
  assign m_axis_tuser[USER_OVF]  = flg[0].overflow || flg[1].overflow || flg[2].overflow;

`ifndef SYNTHESIS
  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[USER_SING]) |->
      (m_axis_tdata == '0 && !m_axis_tuser[USER_OVF]))
    else $error("singular result not cleared");

  a_stall_holds_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output beat changed under stall");
`endif

endmodule
